// ----- src/range_add_range_max_tree_macros.svh -----
// Assertion macros used by the range add / range max tree controller.
// Depends on a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef RANGE_ADD_RANGE_MAX_TREE_MACROS_SVH
`define RANGE_ADD_RANGE_MAX_TREE_MACROS_SVH

// same-cycle implication
`define RARMT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RARMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rarmt_pkg.sv -----
// Package for the range add / range max tree: sizes, item structs, datapath commands.
// No dependencies.
package rarmt_pkg;

    localparam int LEAVES = 1024;
    localparam int LVL    = $clog2(LEAVES);
    localparam int NODE_W = LVL + 1;
    localparam int POS_W  = 10;
    localparam int DATA_W = 32;
    localparam int U_W    = $clog2(LVL + 1);

    localparam logic [DATA_W-1:0] EMPTY_VAL = DATA_W'(-64'sd1231231234);

    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_CLR   = 4'd2;
    localparam logic [3:0] OP_ADDN  = 4'd3;
    localparam logic [3:0] OP_PCLR  = 4'd4;
    localparam logic [3:0] OP_PUSHA = 4'd5;
    localparam logic [3:0] OP_PUSHB = 4'd6;
    localparam logic [3:0] OP_REB   = 4'd7;
    localparam logic [3:0] OP_QRY   = 4'd8;
    localparam logic [3:0] OP_OUT   = 4'd9;
    localparam logic [3:0] OP_OUTE  = 4'd10;

    typedef struct packed {
        logic                     kind;
        logic [POS_W-1:0]         range_low;
        logic [POS_W-1:0]         range_high;
        logic signed [DATA_W-1:0] add_amount;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic                     empty_range;
    } t_out_item;

    typedef struct packed {
        logic [3:0]        op;
        logic              rd;
        logic [NODE_W-1:0] addr_a;
        logic [NODE_W-1:0] addr_b;
        logic [LVL-1:0]    addr_p;
        logic [LVL-1:0]    addr_q;
    } t_dp_cmd;

    typedef struct packed {
        logic pend_nz;
        logic out_free;
    } t_dp_sts;

    function automatic logic [DATA_W-1:0] smax(input logic [DATA_W-1:0] a,
                                               input logic [DATA_W-1:0] b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

    function automatic logic [LVL-1:0] clamp_pos(input logic [POS_W-1:0] pos);
        if (32'(pos) >= LEAVES) begin
            return LVL'(LEAVES - 1);
        end
        return LVL'(pos);
    endfunction

endpackage

// ----- src/range_add_range_max_tree.sv -----
// Range add / range max tree over LEAVES signed 32-bit values.
// Input channel: i_in_valid / o_in_stall with t_in_item; an item transfers when
// valid is high and stall is low. kind 0 adds add_amount over [range_low, range_high],
// kind 1 returns the maximum over that range on the output channel.
// Output channel: o_out_valid / i_out_stall with t_out_item, held while stalled.
// Empty ranges: an add does nothing, a query returns -1231231234 with empty_range set.
// After reset a clearing pass over all 2*LEAVES node addresses zeroes both memories;
// o_in_stall stays high until it finishes.
// One item at a time. Each tree node touched is first read into the read registers,
// then a separate command writes the node/tag memories or, in a query, takes the
// running maximum. An add is a range walk plus two rebuild paths of LVL levels; a
// query is two tag push-down paths of LVL levels each, then the range walk, then the
// move into the output register. The output register frees the input side: a new
// item is taken while a result waits; a query result waits for the register to empty.
// Depends on rarmt_pkg, rarmt_ctrl and rarmt_datapath.
module range_add_range_max_tree import rarmt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    rarmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rarmt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_amount    (i_in_item.add_amount),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- src/rarmt_datapath.sv -----
// Datapath: node and tag memories, read registers, adders, max and output register.
// Depends on rarmt_pkg; driven by rarmt_ctrl commands.
module rarmt_datapath import rarmt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [DATA_W-1:0] i_amount,
    input  logic              i_out_stall,
    output t_dp_sts           o_sts,
    output logic              o_out_valid,
    output t_out_item         o_out_item
);

    logic [DATA_W-1:0] r_node_mem [2*LEAVES];
    logic [DATA_W-1:0] r_pend_mem [LEAVES];

    logic [DATA_W-1:0] r_rd_a, r_rd_b, r_rd_p, r_rd_q;
    logic [NODE_W-1:0] r_ra_a, r_ra_b;
    logic [LVL-1:0]    r_ra_p, r_ra_q;
    logic [DATA_W-1:0] r_amt, r_push, r_best;
    logic              r_have, n_have;
    logic [DATA_W-1:0] n_best;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              node_we, pend_we;
    logic [NODE_W-1:0] node_waddr;
    logic [LVL-1:0]    pend_waddr;
    logic [DATA_W-1:0] node_wdata, pend_wdata;

    always_comb begin
        node_we    = 1'b0;
        pend_we    = 1'b0;
        node_waddr = r_ra_a;
        pend_waddr = r_ra_p;
        node_wdata = '0;
        pend_wdata = '0;
        n_have     = r_have;
        n_best     = r_best;
        case (i_cmd.op)
            OP_LOAD: begin
                n_have = 1'b0;
            end
            OP_CLR: begin
                node_we    = 1'b1;
                node_waddr = i_cmd.addr_a;
                pend_we    = 1'b1;
                pend_waddr = i_cmd.addr_a[LVL-1:0];
            end
            OP_ADDN: begin
                node_we    = 1'b1;
                node_wdata = r_rd_a + r_amt;
                pend_we    = !r_ra_a[LVL];
                pend_waddr = r_ra_a[LVL-1:0];
                pend_wdata = r_rd_p + r_amt;
            end
            OP_PCLR: begin
                pend_we = 1'b1;
            end
            OP_PUSHA: begin
                node_we    = 1'b1;
                node_wdata = r_rd_a + r_push;
                pend_we    = !r_ra_a[LVL];
                pend_wdata = r_rd_p + r_push;
            end
            OP_PUSHB: begin
                node_we    = 1'b1;
                node_waddr = r_ra_b;
                node_wdata = r_rd_b + r_push;
                pend_we    = !r_ra_b[LVL];
                pend_waddr = r_ra_q;
                pend_wdata = r_rd_q + r_push;
            end
            OP_REB: begin
                node_we    = 1'b1;
                node_waddr = {1'b0, r_ra_p};
                node_wdata = smax(r_rd_a, r_rd_b) + r_rd_p;
            end
            OP_QRY: begin
                n_have = 1'b1;
                n_best = r_have ? smax(r_best, r_rd_a) : r_rd_a;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[node_waddr] <= node_wdata;
        end
        if (pend_we) begin
            r_pend_mem[pend_waddr] <= pend_wdata;
        end
        if (i_cmd.rd) begin
            r_rd_a <= r_node_mem[i_cmd.addr_a];
            r_rd_b <= r_node_mem[i_cmd.addr_b];
            r_rd_p <= r_pend_mem[i_cmd.addr_p];
            r_rd_q <= r_pend_mem[i_cmd.addr_q];
            r_ra_a <= i_cmd.addr_a;
            r_ra_b <= i_cmd.addr_b;
            r_ra_p <= i_cmd.addr_p;
            r_ra_q <= i_cmd.addr_q;
        end
        if (i_cmd.op == OP_LOAD) begin
            r_amt <= i_amount;
        end
        if (i_cmd.op == OP_PCLR) begin
            r_push <= r_rd_p;
        end
        r_best <= n_best;
        if (i_cmd.op == OP_OUT) begin
            r_out <= '{max_value: r_best, empty_range: 1'b0};
        end else if (i_cmd.op == OP_OUTE) begin
            r_out <= '{max_value: EMPTY_VAL, empty_range: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_have <= n_have;
            if (i_cmd.op == OP_OUT || i_cmd.op == OP_OUTE) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.pend_nz  = (r_rd_p != '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out;

endmodule

// ----- src/rarmt_ctrl.sv -----
// Controller: clearing pass, range walk, tag push-down and rebuild sequencing.
// Depends on rarmt_pkg and the assertion macro header; drives rarmt_datapath.
`include "range_add_range_max_tree_macros.svh"
module rarmt_ctrl import rarmt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_item,
    output logic     o_in_stall,
    input  t_dp_sts  i_sts,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A_L   = 4'd2;
    localparam logic [3:0] S_A_LW  = 4'd3;
    localparam logic [3:0] S_A_R   = 4'd4;
    localparam logic [3:0] S_A_RW  = 4'd5;
    localparam logic [3:0] S_A_SH  = 4'd6;
    localparam logic [3:0] S_RB    = 4'd7;
    localparam logic [3:0] S_RBW   = 4'd8;
    localparam logic [3:0] S_P_A   = 4'd9;
    localparam logic [3:0] S_P_B   = 4'd10;
    localparam logic [3:0] S_P_C   = 4'd11;
    localparam logic [3:0] S_P_D   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;
    localparam logic [3:0] S_OUTE  = 4'd14;

    logic [3:0]        r_state, n_state;
    logic              r_kind, n_kind;
    logic [LVL-1:0]    r_lo, n_lo, r_hi, n_hi;
    logic [NODE_W:0]   r_l, n_l;
    logic [NODE_W-1:0] r_r, n_r;
    logic [LVL-1:0]    r_n, n_n;
    logic [U_W-1:0]    r_u, n_u;
    logic              r_pass, n_pass;
    logic [NODE_W-1:0] r_clr, n_clr;

    logic [LVL-1:0]    lo_c, hi_c;
    logic [NODE_W-1:0] leaf_lo, leaf_hi, path_node, push_idx, child0, child1;
    t_dp_cmd           cmd;

    assign lo_c      = clamp_pos(i_in_item.range_low);
    assign hi_c      = clamp_pos(i_in_item.range_high);
    assign leaf_lo   = {1'b1, r_lo};
    assign leaf_hi   = {1'b1, r_hi};
    assign path_node = r_pass ? leaf_hi : leaf_lo;
    assign push_idx  = path_node >> r_u;
    assign child0    = {r_n, 1'b0};
    assign child1    = {r_n, 1'b1};

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_l     = r_l;
        n_r     = r_r;
        n_n     = r_n;
        n_u     = r_u;
        n_pass  = r_pass;
        n_clr   = r_clr;
        cmd     = '0;
        cmd.op  = OP_NONE;
        case (r_state)
            S_CLEAR: begin
                cmd.op     = OP_CLR;
                cmd.addr_a = r_clr;
                n_clr      = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.op = OP_LOAD;
                    n_kind = i_in_item.kind;
                    n_lo   = lo_c;
                    n_hi   = hi_c;
                    n_l    = {2'b01, lo_c};
                    n_r    = {1'b1, hi_c};
                    n_u    = U_W'(LVL);
                    n_pass = 1'b0;
                    if (lo_c > hi_c) begin
                        n_state = i_in_item.kind ? S_OUTE : S_IDLE;
                    end else begin
                        n_state = i_in_item.kind ? S_P_A : S_A_L;
                    end
                end
            end
            S_A_L: begin
                if (r_l <= {1'b0, r_r} && r_l != '0) begin
                    if (r_l[0]) begin
                        cmd.rd     = 1'b1;
                        cmd.addr_a = r_l[NODE_W-1:0];
                        cmd.addr_p = r_l[LVL-1:0];
                        n_state    = S_A_LW;
                    end else begin
                        n_state = S_A_R;
                    end
                end else if (r_kind) begin
                    n_state = S_OUT;
                end else begin
                    n_n     = leaf_lo[NODE_W-1:1];
                    n_pass  = 1'b0;
                    n_state = S_RB;
                end
            end
            S_A_LW: begin
                cmd.op  = r_kind ? OP_QRY : OP_ADDN;
                n_l     = r_l + 1'b1;
                n_state = S_A_R;
            end
            S_A_R: begin
                if (!r_r[0]) begin
                    cmd.rd     = 1'b1;
                    cmd.addr_a = r_r;
                    cmd.addr_p = r_r[LVL-1:0];
                    n_state    = S_A_RW;
                end else begin
                    n_state = S_A_SH;
                end
            end
            S_A_RW: begin
                cmd.op  = r_kind ? OP_QRY : OP_ADDN;
                n_r     = r_r - 1'b1;
                n_state = S_A_SH;
            end
            S_A_SH: begin
                n_l     = r_l >> 1;
                n_r     = r_r >> 1;
                n_state = S_A_L;
            end
            S_RB: begin
                if (r_n == '0) begin
                    if (!r_pass) begin
                        n_pass = 1'b1;
                        n_n    = leaf_hi[NODE_W-1:1];
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    cmd.rd     = 1'b1;
                    cmd.addr_a = child0;
                    cmd.addr_b = child1;
                    cmd.addr_p = r_n;
                    n_state    = S_RBW;
                end
            end
            S_RBW: begin
                cmd.op  = OP_REB;
                n_n     = r_n >> 1;
                n_state = S_RB;
            end
            S_P_A: begin
                cmd.rd     = 1'b1;
                cmd.addr_p = push_idx[LVL-1:0];
                n_n        = push_idx[LVL-1:0];
                n_state    = S_P_B;
            end
            S_P_B, S_P_D: begin
                cmd.op = (r_state == S_P_B) ? OP_PCLR : OP_PUSHB;
                if (r_state == S_P_B && i_sts.pend_nz) begin
                    cmd.rd     = 1'b1;
                    cmd.addr_a = child0;
                    cmd.addr_b = child1;
                    cmd.addr_p = child0[LVL-1:0];
                    cmd.addr_q = child1[LVL-1:0];
                    n_state    = S_P_C;
                end else if (r_u == U_W'(1)) begin
                    if (!r_pass) begin
                        n_pass  = 1'b1;
                        n_u     = U_W'(LVL);
                        n_state = S_P_A;
                    end else begin
                        n_state = S_A_L;
                    end
                end else begin
                    n_u     = r_u - 1'b1;
                    n_state = S_P_A;
                end
            end
            S_P_C: begin
                cmd.op  = OP_PUSHA;
                n_state = S_P_D;
            end
            S_OUT, S_OUTE: begin
                if (i_sts.out_free) begin
                    cmd.op  = (r_state == S_OUT) ? OP_OUT : OP_OUTE;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_kind <= n_kind;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_l    <= n_l;
        r_r    <= n_r;
        r_n    <= n_n;
        r_u    <= n_u;
        r_pass <= n_pass;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

    `RARMT_ASSERT_NEXT(a_push_skip, r_state == S_P_B && !i_sts.pend_nz,
        r_state != S_P_C, "push issued for a clear tag")
    `RARMT_ASSERT_NEXT(a_out_hold, r_state == S_OUT && !i_sts.out_free,
        r_state == S_OUT, "result dropped while output busy")
    `RARMT_ASSERT_NEXT(a_empty_add, r_state == S_IDLE && i_in_valid && !i_in_item.kind && lo_c > hi_c,
        r_state == S_IDLE, "empty add did not complete at once")

endmodule
